### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the SHA-1 core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/sha1h_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_pkg
// Types and constants shared by the SHA-1 core and its round unit.
// ----------------------------------------------------------------------------
package sha1h_pkg;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] SCHED_LOAD_ROUNDS = 7'd16;
  localparam logic [6:0] PHASE_1_START     = 7'd20;
  localparam logic [6:0] PHASE_2_START     = 7'd40;
  localparam logic [6:0] PHASE_3_START     = 7'd60;
  localparam logic [6:0] LAST_ROUND        = 7'd79;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  // working variables a..e of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

endpackage

`default_nettype wire

### design/sha1h_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_round
// One SHA-1 round: message schedule word, round function and the a..e update.
// ----------------------------------------------------------------------------
module sha1h_round (
  input  wire logic [6:0]      rnd,
  input  wire sha1h_pkg::work_t work,
  input  wire logic [31:0]     s0,
  input  wire logic [31:0]     s2,
  input  wire logic [31:0]     s8,
  input  wire logic [31:0]     s13,
  output sha1h_pkg::work_t     work_nxt,
  output logic [31:0]          w
);
  import sha1h_pkg::*;

  logic [31:0] mix;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    mix = s13 ^ s8 ^ s2 ^ s0;
    // first 16 rounds use the loaded block words as they are
    w = (rnd < SCHED_LOAD_ROUNDS) ? s0 : {mix[30:0], mix[31]};

    if (rnd < PHASE_1_START) begin
      f = (work.b & work.c) | (~work.b & work.d);
      k = K_0;
    end else if (rnd < PHASE_2_START) begin
      f = work.b ^ work.c ^ work.d;
      k = K_1;
    end else if (rnd < PHASE_3_START) begin
      f = (work.b & work.c) | (work.b & work.d) | (work.c & work.d);
      k = K_2;
    end else begin
      f = work.b ^ work.c ^ work.d;
      k = K_3;
    end

    t = {work.a[26:0], work.a[31:27]} + f + work.e + k + w;

    work_nxt.a = t;
    work_nxt.b = work.a;
    work_nxt.c = {work.b[1:0], work.b[31:2]};
    work_nxt.d = work.c;
    work_nxt.e = work.d;
  end

endmodule

`default_nettype wire

### design/sha1_hash_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_hash_core
// Byte-serial SHA-1 digest engine with one shared round unit.
// ----------------------------------------------------------------------------
// A message byte is taken while busy is low. The byte that completes a
// 64-byte block keeps busy high through 80 rounds on the single round unit,
// then while the result is folded into the chaining words. The request that
// ends the message shifts in the padding one byte per cycle up to the block
// end, then the block is compressed; when fewer than 9 bytes are left in the
// block a second padded block is added. The digest follows as five
// back-to-back single-cycle words on out_valid, index 0 first, out_last_word
// on the fifth; the receiver cannot hold them off. busy drops in the cycle
// after the fifth word, ready for a new message.
// ----------------------------------------------------------------------------
module sha1_hash_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha1h_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] msg_r, msg_nxt;
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [31:0] sched_r [16];
  logic [31:0] sched_nxt [16];
  work_t       work_r, work_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        first_r, first_nxt;   // 0x80 not yet shifted in
  logic        final_r, final_nxt;   // current block carries the length
  logic        fin_r, fin_nxt;       // message end requested
  logic        blkfin_r, blkfin_nxt; // block in compression is the last one

  logic        take;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [5:0]  fill_after;
  work_t       rnd_work;
  logic [31:0] rnd_w;

  assign busy = (state_r != ST_IDLE);
  assign take = start && !busy;

  assign bit_len  = {msg_r, 3'b000};
  assign len_byte = bit_len[{3'd7 - fill_r[2:0], 3'b000} +: 8];

  sha1h_round u_round (
    .rnd      (rnd_r),
    .work     (work_r),
    .s0       (sched_r[0]),
    .s2       (sched_r[2]),
    .s8       (sched_r[8]),
    .s13      (sched_r[13]),
    .work_nxt (rnd_work),
    .w        (rnd_w)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    msg_nxt    = msg_r;
    h_nxt      = h_r;
    work_nxt   = work_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    final_nxt  = final_r;
    fin_nxt    = fin_r;
    blkfin_nxt = blkfin_r;
    shift_en   = 1'b0;
    shift_byte = in_data_byte;
    fill_after = fill_r;

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          fin_nxt    = in_last_byte;
          first_nxt  = 1'b1;
          blkfin_nxt = 1'b0;
          if (in_byte_valid) begin
            shift_en   = 1'b1;
            fill_after = fill_r + 6'd1;
            fill_nxt   = fill_after;
            msg_nxt    = msg_r + 61'd1;
          end
          // length fits behind the 0x80 only below byte 56
          final_nxt = (fill_after[5:3] != 3'b111);
          if (in_byte_valid && (fill_r == 6'd63)) begin
            state_nxt = ST_ROUND;
            rnd_nxt   = '0;
            work_nxt  = '{a: h_r[0], b: h_r[1], c: h_r[2], d: h_r[3], e: h_r[4]};
          end else if (in_last_byte) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_en = 1'b1;
        if (first_r) begin
          shift_byte = PAD_BYTE;
        end else if (final_r && (fill_r[5:3] == 3'b111)) begin
          shift_byte = len_byte;
        end else begin
          shift_byte = 8'h00;
        end
        first_nxt = 1'b0;
        fill_nxt  = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          state_nxt  = ST_ROUND;
          rnd_nxt    = '0;
          blkfin_nxt = final_r;
          work_nxt   = '{a: h_r[0], b: h_r[1], c: h_r[2], d: h_r[3], e: h_r[4]};
        end
      end
      ST_ROUND: begin
        work_nxt = rnd_work;
        rnd_nxt  = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        h_nxt[0] = h_r[0] + work_r.a;
        h_nxt[1] = h_r[1] + work_r.b;
        h_nxt[2] = h_r[2] + work_r.c;
        h_nxt[3] = h_r[3] + work_r.d;
        h_nxt[4] = h_r[4] + work_r.e;
        if (blkfin_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = '0;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
          final_nxt = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        for (int i = 0; i < 4; i++) begin
          h_nxt[i] = h_r[i + 1];
        end
        h_nxt[4] = h_r[0];
        idx_nxt  = idx_r + 3'd1;
        if (idx_r == LAST_WORD_IDX) begin
          h_nxt     = H_INIT;
          fill_nxt  = '0;
          msg_nxt   = '0;
          fin_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // block buffer and schedule share one 16-word shift line
  always_comb begin
    sched_nxt = sched_r;
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_nxt[i] = {sched_r[i][23:0], sched_r[i + 1][31:24]};
      end
      sched_nxt[15] = {sched_r[15][23:0], shift_byte};
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched_nxt[i] = sched_r[i + 1];
      end
      sched_nxt[15] = rnd_w;
    end
  end

  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
    work_r  <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      msg_r    <= '0;
      h_r      <= H_INIT;
      rnd_r    <= '0;
      idx_r    <= '0;
      first_r  <= 1'b0;
      final_r  <= 1'b0;
      fin_r    <= 1'b0;
      blkfin_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      msg_r    <= msg_nxt;
      h_r      <= h_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      first_r  <= first_nxt;
      final_r  <= final_nxt;
      fin_r    <= fin_nxt;
      blkfin_r <= blkfin_nxt;
    end
  end

  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = h_r[0];
  assign out_word_index  = idx_r;
  assign out_last_word   = (state_r == ST_OUT) && (idx_r == LAST_WORD_IDX);

`include "assert_macros.svh"

  `ASSERT_CLK(a_word_seq, out_valid && !out_last_word |=> out_valid && (out_word_index == $past(out_word_index) + 3'd1), "digest words not consecutive")
  `ASSERT_CLK(a_last_idle, out_valid && out_last_word |=> !busy, "not idle after last digest word")
  `ASSERT_CLK(a_round_range, state_r == ST_ROUND |-> rnd_r <= LAST_ROUND, "round counter out of range")
  `ASSERT_CLK(a_out_needs_end, state_r == ST_OUT |-> fin_r, "digest without message end")
  `ASSERT_NEVER(a_pad_no_fill, state_r == ST_PAD && !fin_r, "padding without message end")

endmodule

`default_nettype wire

### dv/tb_sha1_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_hash_core
// Self-checking bench for the byte-serial SHA-1 core: a short table of
// known messages and edge cases, then random messages sized around the block
// and padding boundaries, each digest word checked against a known digest or a local SHA-1 model.
// ----------------------------------------------------------------------------
module tb_sha1_hash_core;

  localparam logic [31:0] RC_0 = 32'h5A827999;
  localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
  localparam logic [31:0] RC_3 = 32'hCA62C1D6;
  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  localparam int DIRECTED_ROWS = 11;
  localparam int PHASES = 3;
  localparam int IDLE_PCT [PHASES] = '{0, 53, 33};
  localparam int EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef struct {
    logic [7:0]   data;
    bit           valid;
    bit           last;
    bit           typed;
    logic [159:0] digest;
  } request_row_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_data_byte;
  logic        in_byte_valid;
  logic        in_last_byte;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // local SHA-1 state
  logic [31:0]  hash_h [5];
  logic [7:0]   msg_block [64];
  int unsigned  block_fill;
  logic [60:0]  msg_len;

  digest_word_t expected_words [$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           msgs_sent = 0;

  // empty message, "abc", then byte extremes and the end-marker cases
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, 1'b0, '0}
  };

  sha1_hash_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data_byte    (in_data_byte),
    .in_byte_valid   (in_byte_valid),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("sha1_hash_core regression: fail");
    $finish;
  end

  function automatic void clear_hash_state();
    for (int i = 0; i < 5; i++) hash_h[i] = SHA1_IV[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    block_fill = 0;
    msg_len = '0;
  endfunction

  function automatic void compress_msg_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wr, t;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        wr = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
        wr = {wr[30:0], wr[31]};
        w[r%16] = wr;
      end else begin
        wr = w[r];
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_2;
      end else begin
        f = b ^ c ^ d;
        k = RC_3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + wr;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_h[0] = hash_h[0] + a;
    hash_h[1] = hash_h[1] + b;
    hash_h[2] = hash_h[2] + c;
    hash_h[3] = hash_h[3] + d;
    hash_h[4] = hash_h[4] + e;
  endfunction

  // takes one request; returns 1 with the digest when it ends a message
  function automatic bit absorb_request(input logic [7:0] d, input bit v, input bit l,
                                        output logic [159:0] dg);
    logic [63:0] bit_len;
    dg = '0;
    if (v) begin
      msg_block[block_fill] = d;
      block_fill++;
      msg_len = msg_len + 61'd1;
      if (block_fill == 64) begin
        compress_msg_block();
        block_fill = 0;
      end
    end
    if (!l) return 1'b0;
    msg_block[block_fill] = PAD_MARK;
    for (int j = block_fill + 1; j < 64; j++) msg_block[j] = 8'h00;
    // no room for the length: spill into a second block
    if (block_fill >= 56) begin
      compress_msg_block();
      for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
    end
    bit_len = {msg_len, 3'b000};
    for (int j = 0; j < 8; j++) msg_block[56+j] = bit_len[63-8*j -: 8];
    compress_msg_block();
    dg = {hash_h[0], hash_h[1], hash_h[2], hash_h[3], hash_h[4]};
    clear_hash_state();
    return 1'b1;
  endfunction

  task automatic send_request(input logic [7:0] d, input bit v, input bit l,
                              input bit typed, input logic [159:0] typed_dg,
                              input int idle_pct);
    logic [159:0] dg;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start         <= 1'b1;
    in_data_byte  <= d;
    in_byte_valid <= v;
    in_last_byte  <= l;
    do @(posedge clk); while (busy);
    if (absorb_request(d, v, l, dg)) begin
      if (typed) dg = typed_dg;
      for (int i = 0; i < 5; i++)
        expected_words.push_back('{dg[159-32*i -: 32], 3'(i), (i == 4)});
    end
    if (v || l) items_sent++;
  endtask

  task automatic send_message(input int idle_pct);
    int len;
    int pick;
    bit end_marker;
    pick = $urandom_range(99);
    if (pick < 15) len = EDGE_LENS[$urandom_range(9)];
    else if (pick < 75) len = $urandom_range(40);
    else len = $urandom_range(140, 41);
    end_marker = (len == 0) || ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8)
        send_request(8'($urandom), 1'b0, 1'b0, 1'b0, '0, idle_pct);
      send_request(8'($urandom), 1'b1, !end_marker && (i == len - 1), 1'b0, '0, idle_pct);
    end
    if (end_marker) send_request(8'($urandom), 1'b0, 1'b1, 1'b0, '0, idle_pct);
    msgs_sent++;
  endtask

  always @(posedge clk) begin : digest_checker
    digest_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", out_digest_word, out_word_index);
        mismatch_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_digest_word !== exp_w.word) begin
          $error("digest_word: expected %h, got %h", exp_w.word, out_digest_word);
          mismatch_count++;
        end
        if (out_word_index !== exp_w.index) begin
          $error("word_index: expected %0d, got %0d", exp_w.index, out_word_index);
          mismatch_count++;
        end
        if (out_last_word !== exp_w.last) begin
          $error("last_word: expected %b, got %b", exp_w.last, out_last_word);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase_items;
    int phase_msgs;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_data_byte  <= 8'h00;
    in_byte_valid <= 1'b0;
    in_last_byte  <= 1'b0;
    clear_hash_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].data, directed_rows[i].valid, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].digest, 0);

    for (int p = 0; p < PHASES; p++) begin
      phase_items = items_sent;
      phase_msgs  = msgs_sent;
      while (items_sent - phase_items < 80 || msgs_sent - phase_msgs < 4)
        send_message(IDLE_PCT[p]);
      // hold off until every digest in flight has come out
      start <= 1'b0;
      do @(posedge clk); while (expected_words.size() != 0);
    end

    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("sha1_hash_core regression: pass");
    else
      $display("sha1_hash_core regression: fail");
    $finish;
  end

endmodule
